// ----- sv/vcdg_pkg.sv -----
// Shared types and constants for the volume central-difference gradient block.
package vcdg_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_I = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_J = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_K = 2'd2;

  localparam logic [8:0]  SIZE_I_RESET = 9'd256;
  localparam logic [8:0]  SIZE_J_RESET = 9'd256;
  localparam logic [10:0] SIZE_K_RESET = 11'd1024;

  // Per-result side data that travels with the ring reads.
  typedef struct packed {
    logic [7:0] pos_i;
    logic [7:0] pos_j;
    logic [9:0] pos_k;
    logic       last;
    logic [7:0] voxel;
  } tag_t;

endpackage

// ----- sv/vcdg_ring_mem.sv -----
// Two-plane voxel ring copy: one write port and two registered read ports.
module vcdg_ring_mem #(
  parameter int DEPTH = 131072,
  parameter int AW    = 17
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic [7:0]    rd_data_a,
  output logic [7:0]    rd_data_b
);

  logic [7:0] mem [DEPTH];

  // Reads return the old contents when they hit the address being written.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ----- sv/vcdg_scan.sv -----
// Size registers, raster counters, interior test and ring addressing.
module vcdg_scan #(
  parameter int MAX_SIZE_I = 256,
  parameter int MAX_SIZE_J = 256,
  parameter int MAX_SIZE_K = 1024,
  parameter int AW         = 17
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [vcdg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [vcdg_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                               cfg_ready,
  input  logic                               accept,
  input  logic [7:0]                         voxel,
  output logic                               hit,
  output vcdg_pkg::tag_t                     tag,
  output logic [AW-1:0]                      wr_addr,
  output logic [AW-1:0]                      rd_addr_ip,
  output logic [AW-1:0]                      rd_addr_im,
  output logic [AW-1:0]                      rd_addr_jp,
  output logic [AW-1:0]                      rd_addr_jm,
  output logic [AW-1:0]                      rd_addr_kc
);

  localparam int IW_I  = $clog2(MAX_SIZE_I);
  localparam int IW_J  = $clog2(MAX_SIZE_J);
  localparam int IW_K  = $clog2(MAX_SIZE_K);
  localparam int EW_I  = $clog2(MAX_SIZE_I + 1);
  localparam int EW_J  = $clog2(MAX_SIZE_J + 1);
  localparam int EW_K  = $clog2(MAX_SIZE_K + 1);
  localparam int PLANE = MAX_SIZE_I * MAX_SIZE_J;

  logic [8:0]       size_i;
  logic [8:0]       size_j;
  logic [10:0]      size_k;
  logic [IW_I-1:0]  ci, ci_next;
  logic [IW_J-1:0]  cj, cj_next;
  logic [IW_K-1:0]  ck, ck_next;
  logic [EW_I-1:0]  ei;
  logic [EW_J-1:0]  ej;
  logic [EW_K-1:0]  ek;
  logic             big;
  logic             last;
  logic             mid;

  function automatic logic [AW-1:0] ring_addr(input logic plane, input int i, input int j);
    int flat;
    flat = (plane ? PLANE : 0) + j * MAX_SIZE_I + i;
    return AW'(flat);
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_i <= vcdg_pkg::SIZE_I_RESET;
      size_j <= vcdg_pkg::SIZE_J_RESET;
      size_k <= vcdg_pkg::SIZE_K_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vcdg_pkg::REG_SIZE_I: size_i <= cfg_data[8:0];
        vcdg_pkg::REG_SIZE_J: size_j <= cfg_data[8:0];
        vcdg_pkg::REG_SIZE_K: size_k <= cfg_data;
        default: ;
      endcase
    end
  end

  // A size above the maximum acts as the maximum; zero counts as one.
  always_comb begin
    if (int'(size_i) > MAX_SIZE_I) ei = EW_I'(MAX_SIZE_I);
    else if (size_i == '0)         ei = EW_I'(1);
    else                           ei = EW_I'(size_i);
    if (int'(size_j) > MAX_SIZE_J) ej = EW_J'(MAX_SIZE_J);
    else if (size_j == '0)         ej = EW_J'(1);
    else                           ej = EW_J'(size_j);
    if (int'(size_k) > MAX_SIZE_K) ek = EW_K'(MAX_SIZE_K);
    else if (size_k == '0)         ek = EW_K'(1);
    else                           ek = EW_K'(size_k);
  end

  always_comb begin
    big  = (size_i > 9'd2) && (size_j > 9'd2) && (size_k > 11'd2);
    hit  = big && (int'(ck) >= 2) && (int'(ck) < int'(ek)) &&
           (int'(ci) >= 1) && (int'(ci) + 2 <= int'(ei)) &&
           (int'(cj) >= 1) && (int'(cj) + 2 <= int'(ej));
    last = (int'(ci) + 2 == int'(ei)) && (int'(cj) + 2 == int'(ej)) &&
           (int'(ck) + 1 == int'(ek));
  end

  always_comb begin
    ci_next = ci + IW_I'(1);
    cj_next = cj;
    ck_next = ck;
    if (int'(ci) + 1 >= int'(ei)) begin
      ci_next = '0;
      cj_next = cj + IW_J'(1);
      if (int'(cj) + 1 >= int'(ej)) begin
        cj_next = '0;
        ck_next = ck + IW_K'(1);
        if (int'(ck) + 1 >= int'(ek)) begin
          ck_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ci <= '0;
      cj <= '0;
      ck <= '0;
    end else if (accept) begin
      ci <= ci_next;
      cj <= cj_next;
      ck <= ck_next;
    end
  end

  // The plane slot of k-2 is read for the k difference and then overwritten with plane k.
  assign mid        = ~ck[0];
  assign wr_addr    = ring_addr(ck[0], int'(ci), int'(cj));
  assign rd_addr_kc = ring_addr(ck[0], int'(ci), int'(cj));
  assign rd_addr_ip = ring_addr(mid, int'(ci) + 1, int'(cj));
  assign rd_addr_im = ring_addr(mid, int'(ci) - 1, int'(cj));
  assign rd_addr_jp = ring_addr(mid, int'(ci), int'(cj) + 1);
  assign rd_addr_jm = ring_addr(mid, int'(ci), int'(cj) - 1);

  always_comb begin
    tag.pos_i = 8'(ci);
    tag.pos_j = 8'(cj);
    tag.pos_k = 10'(ck - IW_K'(1));
    tag.last  = last;
    tag.voxel = voxel;
  end

endmodule

// ----- sv/vcdg_pipe.sv -----
// Difference and magnitude pipeline with per-stage flow control and result register.
module vcdg_pipe (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                hit,
  input  vcdg_pkg::tag_t      tag,
  input  logic [7:0]          d_ip,
  input  logic [7:0]          d_im,
  input  logic [7:0]          d_jp,
  input  logic [7:0]          d_jm,
  input  logic [7:0]          d_kc,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          pos_i,
  output logic [7:0]          pos_j,
  output logic [9:0]          pos_k,
  output logic signed [8:0]   grad_along_i,
  output logic signed [8:0]   grad_along_j,
  output logic signed [8:0]   grad_along_k,
  output logic [17:0]         mag_squared,
  output logic                final_voxel
);

  logic                v1;
  logic                v2;
  logic                en1, en2, en3;
  vcdg_pkg::tag_t      tag1;
  vcdg_pkg::tag_t      tag2;
  logic signed [8:0]   gi_next, gj_next, gk_next;
  logic signed [8:0]   gi2, gj2, gk2;
  logic signed [17:0]  prod_i, prod_j, prod_k;
  logic [17:0]         mag_next;

  // Each stage moves when the one after it is empty or moving.
  assign en3      = !out_valid || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  assign gi_next = $signed({1'b0, d_ip}) - $signed({1'b0, d_im});
  assign gj_next = $signed({1'b0, d_jp}) - $signed({1'b0, d_jm});
  assign gk_next = $signed({1'b0, tag1.voxel}) - $signed({1'b0, d_kc});

  assign prod_i   = gi2 * gi2;
  assign prod_j   = gj2 * gj2;
  assign prod_k   = gk2 * gk2;
  assign mag_next = $unsigned(prod_i) + $unsigned(prod_j) + $unsigned(prod_k);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= accept && hit;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hit) begin
      tag1 <= tag;
    end
    if (en2 && v1) begin
      tag2 <= tag1;
      gi2  <= gi_next;
      gj2  <= gj_next;
      gk2  <= gk_next;
    end
    if (en3 && v2) begin
      pos_i        <= tag2.pos_i;
      pos_j        <= tag2.pos_j;
      pos_k        <= tag2.pos_k;
      final_voxel  <= tag2.last;
      grad_along_i <= gi2;
      grad_along_j <= gj2;
      grad_along_k <= gk2;
      mag_squared  <= mag_next;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && out_valid))
    else $error("input stalled while the pipeline has room");

  a_mag_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (int'(mag_squared) ==
      int'(grad_along_i) * int'(grad_along_i) + int'(grad_along_j) * int'(grad_along_j) +
      int'(grad_along_k) * int'(grad_along_k)))
    else $error("magnitude does not match the presented differences");

  a_next_result_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && v2) |=> out_valid)
    else $error("waiting result was not moved into the output register");

endmodule

// ----- sv/volume_central_difference_gradient.sv -----
// A result passes the read, difference and output registers after the voxel at k+1 is accepted.
// One voxel per cycle unless stalled; each voxel does one ring write, interior ones five reads,
// served by three copies of the two-plane ring, each with one write and two read ports.
// Output back-pressure reaches the input only once all three stages hold results.
// Reset clears the raster counters and stage valids and sets the sizes to 256, 256 and 1024.
// Ring contents are not cleared; no clearing pass follows reset.
module volume_central_difference_gradient #(
  parameter int MAX_SIZE_I = 256,
  parameter int MAX_SIZE_J = 256,
  parameter int MAX_SIZE_K = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vcdg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [vcdg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        voxel,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        pos_i,
  output logic [7:0]                        pos_j,
  output logic [9:0]                        pos_k,
  output logic signed [8:0]                 grad_along_i,
  output logic signed [8:0]                 grad_along_j,
  output logic signed [8:0]                 grad_along_k,
  output logic [17:0]                       mag_squared,
  output logic                              final_voxel
);

  localparam int DEPTH = 2 * MAX_SIZE_I * MAX_SIZE_J;
  localparam int AW    = $clog2(DEPTH);

  logic            accept;
  logic            hit;
  logic            rd_en;
  vcdg_pkg::tag_t  tag;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr_ip, rd_addr_im, rd_addr_jp, rd_addr_jm, rd_addr_kc;
  logic [7:0]      d_ip, d_im, d_jp, d_jm, d_kc;

  assign accept = in_valid && !in_stall;
  assign rd_en  = accept && hit;

  vcdg_scan #(
    .MAX_SIZE_I (MAX_SIZE_I),
    .MAX_SIZE_J (MAX_SIZE_J),
    .MAX_SIZE_K (MAX_SIZE_K),
    .AW         (AW)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg_ready  (cfg_ready),
    .accept     (accept),
    .voxel      (voxel),
    .hit        (hit),
    .tag        (tag),
    .wr_addr    (wr_addr),
    .rd_addr_ip (rd_addr_ip),
    .rd_addr_im (rd_addr_im),
    .rd_addr_jp (rd_addr_jp),
    .rd_addr_jm (rd_addr_jm),
    .rd_addr_kc (rd_addr_kc)
  );

  vcdg_ring_mem #(.DEPTH(DEPTH), .AW(AW)) u_ring_i (
    .clk       (clk),
    .wr_en     (accept),
    .wr_addr   (wr_addr),
    .wr_data   (voxel),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_ip),
    .rd_addr_b (rd_addr_im),
    .rd_data_a (d_ip),
    .rd_data_b (d_im)
  );

  vcdg_ring_mem #(.DEPTH(DEPTH), .AW(AW)) u_ring_j (
    .clk       (clk),
    .wr_en     (accept),
    .wr_addr   (wr_addr),
    .wr_data   (voxel),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_jp),
    .rd_addr_b (rd_addr_jm),
    .rd_data_a (d_jp),
    .rd_data_b (d_jm)
  );

  // Only one port of this copy is needed, for the voxel two planes back.
  vcdg_ring_mem #(.DEPTH(DEPTH), .AW(AW)) u_ring_k (
    .clk       (clk),
    .wr_en     (accept),
    .wr_addr   (wr_addr),
    .wr_data   (voxel),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_kc),
    .rd_addr_b (rd_addr_kc),
    .rd_data_a (d_kc),
    .rd_data_b ()
  );

  vcdg_pipe u_pipe (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .hit          (hit),
    .tag          (tag),
    .d_ip         (d_ip),
    .d_im         (d_im),
    .d_jp         (d_jp),
    .d_jm         (d_jm),
    .d_kc         (d_kc),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pos_i        (pos_i),
    .pos_j        (pos_j),
    .pos_k        (pos_k),
    .grad_along_i (grad_along_i),
    .grad_along_j (grad_along_j),
    .grad_along_k (grad_along_k),
    .mag_squared  (mag_squared),
    .final_voxel  (final_voxel)
  );

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the volume central-difference gradient block.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned MAX_I = 256;
  localparam int unsigned MAX_J = 256;
  localparam int unsigned MAX_K = 1024;
  localparam int unsigned ITEM_TARGET = 1550;
  localparam int unsigned QUIET_TAIL = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam logic [vcdg_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [7:0]        pos_i;
    logic [7:0]        pos_j;
    logic [9:0]        pos_k;
    logic signed [8:0] grad_i;
    logic signed [8:0] grad_j;
    logic signed [8:0] grad_k;
    logic [17:0]       mag;
    logic              final_flag;
  } gradient_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [vcdg_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [vcdg_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [7:0]                       voxel = 8'd0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [7:0]                       pos_i;
  logic [7:0]                       pos_j;
  logic [9:0]                       pos_k;
  logic signed [8:0]                grad_along_i;
  logic signed [8:0]                grad_along_j;
  logic signed [8:0]                grad_along_k;
  logic [17:0]                      mag_squared;
  logic                             final_voxel;

  // Stimulus bookkeeping.
  logic [7:0]  voxel_pending [$];
  int unsigned items_fed = 0;
  int unsigned voxels_accepted = 0;
  logic        in_taken = 1'b0;
  logic        idling = 1'b1;
  int unsigned send_gap = 0;
  int unsigned stall_burst = 0;
  logic        long_hold_req = 1'b0;
  logic        long_hold_begun = 1'b0;
  int unsigned long_hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;

  // Shadow of the block: size registers, raster position and the two-plane store.
  logic [8:0]  size_i_reg = vcdg_pkg::SIZE_I_RESET;
  logic [8:0]  size_j_reg = vcdg_pkg::SIZE_J_RESET;
  logic [10:0] size_k_reg = vcdg_pkg::SIZE_K_RESET;
  int unsigned at_i = 0;
  int unsigned at_j = 0;
  int unsigned at_k = 0;
  bit [7:0]    plane_store [2][MAX_J][MAX_I];
  gradient_t   gradients_due [$];

  volume_central_difference_gradient dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .voxel        (voxel),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pos_i        (pos_i),
    .pos_j        (pos_j),
    .pos_k        (pos_k),
    .grad_along_i (grad_along_i),
    .grad_along_j (grad_along_j),
    .grad_along_k (grad_along_k),
    .mag_squared  (mag_squared),
    .final_voxel  (final_voxel)
  );

  always #2 clk = ~clk;

  function automatic int unsigned extent(input int unsigned value, input int unsigned limit);
    if (value > limit) return limit;
    if (value == 0) return 1;
    return value;
  endfunction

  function automatic void advance_raster(inout int unsigned ci, cj, ck,
                                         input int unsigned ei, ej, ek);
    ci++;
    if (ci >= ei) begin
      ci = 0;
      cj++;
      if (cj >= ej) begin
        cj = 0;
        ck++;
        if (ck >= ek) ck = 0;
      end
    end
  endfunction

  // Number of beats that bring the raster position back to the volume origin.
  function automatic int unsigned raster_steps_left();
    int unsigned ci, cj, ck, steps;
    ci = at_i;
    cj = at_j;
    ck = at_k;
    steps = 0;
    do begin
      advance_raster(ci, cj, ck, extent(size_i_reg, MAX_I), extent(size_j_reg, MAX_J),
                     extent(size_k_reg, MAX_K));
      steps++;
    end while (ci != 0 || cj != 0 || ck != 0);
    return steps;
  endfunction

  task automatic predict_gradient(input logic [7:0] v);
    int unsigned ei, ej, ek, mid;
    int di, dj, dk, mag;
    gradient_t g;
    ei = extent(size_i_reg, MAX_I);
    ej = extent(size_j_reg, MAX_J);
    ek = extent(size_k_reg, MAX_K);
    if (size_i_reg > 2 && size_j_reg > 2 && size_k_reg > 2 && at_k >= 2 && at_k < ek &&
        at_i >= 1 && at_i + 2 <= ei && at_j >= 1 && at_j + 2 <= ej) begin
      mid = at_k - 1;
      di = int'(plane_store[mid % 2][at_j][at_i + 1]) -
           int'(plane_store[mid % 2][at_j][at_i - 1]);
      dj = int'(plane_store[mid % 2][at_j + 1][at_i]) -
           int'(plane_store[mid % 2][at_j - 1][at_i]);
      dk = int'(v) - int'(plane_store[at_k % 2][at_j][at_i]);
      mag = di * di + dj * dj + dk * dk;
      g.pos_i = at_i[7:0];
      g.pos_j = at_j[7:0];
      g.pos_k = mid[9:0];
      g.grad_i = di[8:0];
      g.grad_j = dj[8:0];
      g.grad_k = dk[8:0];
      g.mag = mag[17:0];
      g.final_flag = (at_i + 2 == ei) && (at_j + 2 == ej) && (at_k + 1 == ek);
      gradients_due.push_back(g);
    end
    // The slot of plane k-2 is read above before plane k overwrites it.
    plane_store[at_k % 2][at_j][at_i] = v;
    advance_raster(at_i, at_j, at_k, ei, ej, ek);
  endtask

  task automatic check_gradient();
    gradient_t want;
    if (gradients_due.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("unexpected gradient beat at (%0d,%0d,%0d)", pos_i, pos_j, pos_k);
    end else begin
      want = gradients_due.pop_front();
      if (pos_i !== want.pos_i || pos_j !== want.pos_j || pos_k !== want.pos_k ||
          grad_along_i !== want.grad_i || grad_along_j !== want.grad_j ||
          grad_along_k !== want.grad_k || mag_squared !== want.mag ||
          final_voxel !== want.final_flag) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("gradient mismatch, expected pos (%0d,%0d,%0d) grad %0d %0d %0d",
                   want.pos_i, want.pos_j, want.pos_k, want.grad_i, want.grad_j,
                   want.grad_k, " mag %0d last %0b", want.mag, want.final_flag);
          $display("                   actual   pos (%0d,%0d,%0d) grad %0d %0d %0d",
                   pos_i, pos_j, pos_k, grad_along_i, grad_along_j, grad_along_k,
                   " mag %0d last %0b", mag_squared, final_voxel);
        end
      end
    end
  endtask

  // Sample every handshake at the rising edge; update the shadow and check results.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
      size_i_reg = vcdg_pkg::SIZE_I_RESET;
      size_j_reg = vcdg_pkg::SIZE_J_RESET;
      size_k_reg = vcdg_pkg::SIZE_K_RESET;
      at_i = 0;
      at_j = 0;
      at_k = 0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vcdg_pkg::REG_SIZE_I: size_i_reg = cfg_data[8:0];
          vcdg_pkg::REG_SIZE_J: size_j_reg = cfg_data[8:0];
          vcdg_pkg::REG_SIZE_K: size_k_reg = cfg_data[10:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_gradient(voxel);
        voxels_accepted++;
      end
      if (out_valid && !out_stall) check_gradient();
    end
  end

  // Voxel driver.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (voxel_pending.size() != 0) begin
        in_valid <= 1'b1;
        voxel <= voxel_pending.pop_front();
        if (idling && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: short random stall bursts, plus one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (long_hold_req && !long_hold_begun) begin
      long_hold_begun <= 1'b1;
      long_hold_left <= LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (long_hold_left != 0) begin
      long_hold_left <= long_hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_burst != 0) begin
      stall_burst <= stall_burst - 1;
      out_stall <= 1'b1;
    end else if (idling && !out_stall && $urandom_range(0, 5) == 0) begin
      stall_burst <= $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d gradients outstanding", cycle_count,
               gradients_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk); while (voxels_accepted != items_fed || gradients_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [vcdg_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [vcdg_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_sizes(input int unsigned ni, nj, nk);
    write_register(vcdg_pkg::REG_SIZE_I, vcdg_pkg::CFG_DATA_W'(ni));
    write_register(vcdg_pkg::REG_SIZE_J, vcdg_pkg::CFG_DATA_W'(nj));
    write_register(vcdg_pkg::REG_SIZE_K, vcdg_pkg::CFG_DATA_W'(nk));
  endtask

  task automatic feed_voxels(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0)
        voxel_pending.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
      else
        voxel_pending.push_back(8'($urandom_range(0, 255)));
      items_fed++;
    end
  endtask

  initial begin
    logic [7:0]  probe [36];
    int unsigned span, ni, nj, nk;

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // A 4x3x3 volume with two interior voxels: every difference at full negative
    // swing on the first and full positive swing on the second.
    set_sizes(4, 3, 3);
    foreach (probe[n]) probe[n] = 8'h00;
    probe[1*12 + 1*4 + 0] = 8'hFF;
    probe[1*12 + 1*4 + 3] = 8'hFF;
    probe[1*12 + 0*4 + 1] = 8'hFF;
    probe[1*12 + 2*4 + 2] = 8'hFF;
    probe[0*12 + 1*4 + 1] = 8'hFF;
    probe[2*12 + 1*4 + 2] = 8'hFF;
    foreach (probe[n]) begin
      voxel_pending.push_back(probe[n]);
      items_fed++;
    end
    wait_idle();

    // This volume writes every store entry that later gradient reads can reach. The receiver
    // holds off meanwhile so that the block backs up into its input.
    set_sizes(12, 10, 3);
    idling <= 1'b0;
    long_hold_req <= 1'b1;
    feed_voxels(360);
    wait_idle();
    idling <= 1'b1;

    // Volumes too thin along one axis give no gradients.
    set_sizes(2, 5, 4);
    feed_voxels(raster_steps_left());
    wait_idle();
    set_sizes(5, 2, 3);
    feed_voxels(raster_steps_left());
    wait_idle();
    set_sizes(5, 5, 2);
    feed_voxels(raster_steps_left());
    wait_idle();
    set_sizes(0, 0, 0);
    feed_voxels(3);
    wait_idle();

    // Largest and oversized sizes, left mid-volume by shrinking the size.
    set_sizes(256, 1, 1);
    feed_voxels(10);
    wait_idle();
    write_register(vcdg_pkg::REG_SIZE_I, 11'h7FF);
    feed_voxels(10);
    wait_idle();
    write_register(vcdg_pkg::REG_SIZE_I, 11'd1);
    feed_voxels(raster_steps_left());
    wait_idle();
    set_sizes(1, 256, 1);
    feed_voxels(7);
    wait_idle();
    write_register(vcdg_pkg::REG_SIZE_J, 11'h7FF);
    feed_voxels(7);
    wait_idle();
    write_register(vcdg_pkg::REG_SIZE_J, 11'd2);
    feed_voxels(raster_steps_left());
    wait_idle();
    set_sizes(1, 1, 1024);
    feed_voxels(5);
    wait_idle();
    write_register(vcdg_pkg::REG_SIZE_K, 11'h7FF);
    write_register(REG_UNUSED, vcdg_pkg::CFG_DATA_W'($urandom));
    feed_voxels(5);
    wait_idle();
    write_register(vcdg_pkg::REG_SIZE_K, 11'd0);
    feed_voxels(raster_steps_left());
    wait_idle();

    // Random volumes: mostly whole ones, some thin, some cut short by a size change.
    while (items_fed < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0) begin
        ni = $urandom_range(0, 6);
        nj = $urandom_range(0, 6);
        nk = $urandom_range(0, 3);
        case ($urandom_range(0, 2))
          0: ni = $urandom_range(0, 2);
          1: nj = $urandom_range(0, 2);
          default: nk = $urandom_range(0, 2);
        endcase
      end else begin
        ni = $urandom_range(3, 12);
        nj = $urandom_range(3, 10);
        nk = $urandom_range(3, 4);
      end
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0: write_register(vcdg_pkg::REG_SIZE_I, vcdg_pkg::CFG_DATA_W'(ni));
          1: write_register(vcdg_pkg::REG_SIZE_J, vcdg_pkg::CFG_DATA_W'(nj));
          default: write_register(vcdg_pkg::REG_SIZE_K, vcdg_pkg::CFG_DATA_W'(nk));
        endcase
      end else begin
        set_sizes(ni, nj, nk);
      end
      span = raster_steps_left();
      if (span > 1 && $urandom_range(0, 3) == 0) span = $urandom_range(1, span - 1);
      idling <= (items_fed + QUIET_TAIL < ITEM_TARGET) && ($urandom_range(0, 3) != 0);
      feed_voxels(span);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/vcdg_pkg.sv
sv/vcdg_ring_mem.sv
sv/vcdg_scan.sv
sv/vcdg_pipe.sv
sv/volume_central_difference_gradient.sv
dv/testbench.sv
